// ===== hw/rtl/svpwm_pkg.sv =====
// Shared constants and types for the servo PWM channel allocator.
`default_nettype none

package svpwm_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int PRESC_W    = 8;
  localparam int PERIOD_W   = 16;
  localparam int PIN_W      = 8;
  localparam int DUTY_W     = 16;
  localparam int CMD_W      = 2;
  localparam int PWM_W      = 4;
  localparam int IDX_W      = 2;

  localparam int IN_DATA_W  = ((PIN_W + DUTY_W + 7) / 8) * 8;
  localparam int OUT_BITS   = PWM_W + IDX_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PRESC_W-1:0]  PRESC_RESET  = PRESC_W'(11);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ATTACH = 2'd1,
    CMD_DETACH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESCALE = 1'b0,
    REG_PERIOD   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [PWM_W-1:0] pwm;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/servo_pwm_channel_allocator.sv =====
// Four-channel servo PWM timer with pin-to-channel allocation, one item per cycle
// while in_tready is high.
// Input channel (in_*): one beat per command. in_tuser carries the command:
// tick (one core clock of the timer), attach a pin with a duty, detach a pin.
// Every accepted beat yields exactly one result beat on out_*: the output
// levels after that command, plus the channel found or assigned and a flag.
// Configuration (cfg_*): write prescale divide (index 0) or period counts
// (index 1) while the block is idle; a write takes effect on the next edge.
// An accepted beat's result is registered, in the skid stage if out_* is held.
// Throughput: one beat per cycle while in_tready is high; the state update is
// a single pass of logic between the accepting edge and the result register.
// Stall: a result register plus one skid stage decouple the sides; in_tready
// drops only while both hold results the receiver has not yet taken.
// Reset (rst_n low, synchronous): prescaler, period count, match values and
// output levels clear, every channel becomes free, registers return to
// prescale 11 and period 20000, and both result stages empty.
`default_nettype none

module servo_pwm_channel_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [7:0] pin, [23:8] duty
  input  wire logic [svpwm_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] command
  input  wire logic [svpwm_pkg::CMD_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [3:0] pwm_out, [5:4] channel_index, [6] channel_found, [7] zero
  output logic [svpwm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [svpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [svpwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import svpwm_pkg::*;

  logic [PRESC_W-1:0]  presc_div_r;
  logic [PERIOD_W-1:0] period_cnts_r;

  logic [PRESC_W-1:0]  presc_cnt_r, presc_cnt_nxt;
  logic [PERIOD_W-1:0] period_cnt_r, period_cnt_nxt;
  logic [DUTY_W-1:0]   active_r [CHANNELS];
  logic [DUTY_W-1:0]   active_nxt [CHANNELS];
  logic [DUTY_W-1:0]   shadow_r [CHANNELS];
  logic [DUTY_W-1:0]   shadow_nxt [CHANNELS];
  logic [CHANNELS-1:0] levels_r, levels_nxt;
  logic [CHANNELS-1:0] used_r, used_nxt;
  logic [PIN_W-1:0]    pin_map_r [CHANNELS];

  logic                out_valid_r, skid_valid_r;
  res_t                out_res_r, skid_res_r, res;

  cmd_t                cmd;
  logic [PIN_W-1:0]    pin;
  logic [DUTY_W-1:0]   duty;
  logic                in_fire, out_fire;

  logic                pin_hit, free_hit;
  logic [CH_W-1:0]     pin_idx, free_idx, sel_idx;
  logic                sel_ok, map_we;
  logic                count_evt, at_limit;
  logic [CHANNELS-1:0] clr_hit;

  assign cmd  = cmd_t'(in_tuser);
  assign pin  = in_tdata[PIN_W-1:0];
  assign duty = in_tdata[PIN_W +: DUTY_W];

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // Channel search: last match in ascending order is the highest channel.
  always_comb begin
    pin_hit  = 1'b0;
    pin_idx  = '0;
    free_hit = 1'b0;
    free_idx = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (used_r[ch] && (pin_map_r[ch] == pin)) begin
        pin_hit = 1'b1;
        pin_idx = CH_W'(ch);
      end
      if (!used_r[ch]) begin
        free_hit = 1'b1;
        free_idx = CH_W'(ch);
      end
    end
  end

  assign at_limit = (period_cnt_r == (period_cnts_r - PERIOD_W'(1)));

  always_comb begin
    presc_cnt_nxt  = presc_cnt_r;
    period_cnt_nxt = period_cnt_r;
    levels_nxt     = levels_r;
    used_nxt       = used_r;
    active_nxt     = active_r;
    shadow_nxt     = shadow_r;
    count_evt      = 1'b0;
    sel_ok         = 1'b0;
    sel_idx        = '0;
    map_we         = 1'b0;
    clr_hit        = '0;

    unique case (cmd)
      CMD_TICK: begin
        if (presc_cnt_r == presc_div_r) begin
          presc_cnt_nxt = '0;
          count_evt     = 1'b1;
        end else begin
          presc_cnt_nxt = presc_cnt_r + PRESC_W'(1);
        end
      end
      CMD_ATTACH: begin
        sel_ok  = pin_hit || free_hit;
        sel_idx = pin_hit ? pin_idx : free_idx;
        if (sel_ok) begin
          used_nxt[sel_idx]   = 1'b1;
          shadow_nxt[sel_idx] = duty;
          map_we              = 1'b1;
        end
      end
      CMD_DETACH: begin
        sel_ok  = pin_hit;
        sel_idx = pin_idx;
        if (pin_hit) begin
          used_nxt[pin_idx] = 1'b0;
        end
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase

    if (count_evt) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        clr_hit[ch] = (period_cnt_r == active_r[ch]);
        // Set and clear on the same count: hold the level.
        if (at_limit && !clr_hit[ch]) begin
          levels_nxt[ch] = 1'b1;
        end else if (clr_hit[ch] && !at_limit) begin
          levels_nxt[ch] = 1'b0;
        end
      end
      if (at_limit) begin
        period_cnt_nxt = '0;
        active_nxt     = shadow_r;
      end else begin
        period_cnt_nxt = period_cnt_r + PERIOD_W'(1);
      end
    end

    res.pwm   = PWM_W'(levels_nxt);
    res.found = sel_ok;
    res.idx   = sel_ok ? IDX_W'(sel_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_div_r   <= PRESC_RESET;
      period_cnts_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRESCALE: presc_div_r   <= cfg_wdata[PRESC_W-1:0];
        REG_PERIOD:   period_cnts_r <= cfg_wdata[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_cnt_r  <= '0;
      period_cnt_r <= '0;
      levels_r     <= '0;
      used_r       <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        active_r[ch] <= '0;
        shadow_r[ch] <= '0;
      end
    end else if (in_fire) begin
      presc_cnt_r  <= presc_cnt_nxt;
      period_cnt_r <= period_cnt_nxt;
      levels_r     <= levels_nxt;
      used_r       <= used_nxt;
      active_r     <= active_nxt;
      shadow_r     <= shadow_nxt;
    end
  end

  // Pin map holds no reset; entries are read only behind their used bit.
  always_ff @(posedge clk) begin
    if (in_fire && map_we) begin
      pin_map_r[sel_idx] <= pin;
    end
  end

  // Result register plus skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (in_fire) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the result register is empty");

  a_limit_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && count_evt && at_limit) |=> (period_cnt_r == '0))
    else $error("period count did not return to zero at the limit");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.found) |-> (out_res_r.idx == '0))
    else $error("channel index nonzero on a result with no channel");

  a_attach_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && map_we) |=> (used_r != '0))
    else $error("attach left every channel free");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_servo_pwm_channel_allocator.sv =====
// Self-checking testbench for the servo PWM channel allocator: predicts and checks every result beat.
`timescale 1ns / 1ps

module tb_servo_pwm_channel_allocator;
  import svpwm_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int RANDOM_ITEMS   = 1900;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  servo_pwm_channel_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timer and allocator state as the testbench sees it
  logic [PRESC_W-1:0]  div_setting;
  logic [PERIOD_W-1:0] period_setting;
  logic [PRESC_W-1:0]  presc_q;
  logic [PERIOD_W-1:0] count_q;
  logic [DUTY_W-1:0]   match_live [CHANNELS];
  logic [DUTY_W-1:0]   match_next [CHANNELS];
  logic [PWM_W-1:0]    levels_q;
  logic [PIN_W-1:0]    owner_pin [CHANNELS];
  logic                busy [CHANNELS];

  res_t expected_q [$];

  int errors          = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int count_events    = 0;
  int periods_done    = 0;
  int attach_ok       = 0;
  int attach_refused  = 0;
  int reg_writes      = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int cycles          = 0;

  task automatic timer_reset();
    div_setting    = PRESC_RESET;
    period_setting = PERIOD_RESET;
    presc_q        = '0;
    count_q        = '0;
    levels_q       = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      match_live[ch] = '0;
      match_next[ch] = '0;
      owner_pin[ch]  = '0;
      busy[ch]       = 1'b0;
    end
  endtask

  function automatic int owner_of(logic [PIN_W-1:0] pin);
    for (int ch = CHANNELS - 1; ch >= 0; ch--)
      if (busy[ch] && owner_pin[ch] == pin) return ch;
    return -1;
  endfunction

  function automatic int top_free();
    for (int ch = CHANNELS - 1; ch >= 0; ch--)
      if (!busy[ch]) return ch;
    return -1;
  endfunction

  function automatic void count_advance();
    logic [PERIOD_W-1:0] lim;
    logic                at_lim;
    logic                clr;
    lim    = period_setting - 1'b1;
    at_lim = (count_q == lim);
    count_events++;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      clr = (count_q == match_live[ch]);
      // set and clear on the same count: hold the level
      if (at_lim && !clr) levels_q[ch] = 1'b1;
      else if (clr && !at_lim) levels_q[ch] = 1'b0;
    end
    if (at_lim) begin
      count_q = '0;
      periods_done++;
      for (int ch = 0; ch < CHANNELS; ch++) match_live[ch] = match_next[ch];
    end else begin
      count_q = count_q + 1'b1;
    end
  endfunction

  function automatic res_t apply_command(cmd_t cmd, logic [PIN_W-1:0] pin,
                                         logic [DUTY_W-1:0] duty);
    int   ch;
    res_t r;
    ch = -1;
    case (cmd)
      CMD_TICK: begin
        if (presc_q == div_setting) begin
          presc_q = '0;
          count_advance();
        end else begin
          presc_q = presc_q + 1'b1;
        end
      end
      CMD_ATTACH: begin
        ch = owner_of(pin);
        if (ch < 0) ch = top_free();
        if (ch >= 0) begin
          busy[ch]       = 1'b1;
          owner_pin[ch]  = pin;
          match_next[ch] = duty;
          attach_ok++;
        end else begin
          attach_refused++;
        end
      end
      CMD_DETACH: begin
        ch = owner_of(pin);
        if (ch >= 0) busy[ch] = 1'b0;
      end
      default: ;
    endcase
    r.pwm   = levels_q;
    r.found = (ch >= 0);
    r.idx   = (ch >= 0) ? ch[IDX_W-1:0] : '0;
    return r;
  endfunction

  task automatic send_beat(cmd_t cmd, logic [PIN_W-1:0] pin, logic [DUTY_W-1:0] duty);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {duty, pin};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(apply_command(cmd, pin, duty));
    beats_sent++;
  endtask

  // Stop offering and hold until every expected beat has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PRESCALE) div_setting = value[PRESC_W-1:0];
    else period_setting = value;
    reg_writes++;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      1:       begin send_idle_pct = 75; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 75; end
      3:       begin send_idle_pct = 34; stall_pct = 34; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[OUT_BITS-1:0]);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got pwm %h ch %0d found %0b",
                 $time, got.pwm, got.idx, got.found);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch, expected pwm %h ch %0d found %0b, got pwm %h ch %0d found %0b",
                   $time, want.pwm, want.idx, want.found, got.pwm, got.idx, got.found);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d beats still outstanding", cycles, expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_after_reset();
    set_idle(0);
    send_beat(CMD_TICK, '0, '0);
    send_beat(CMD_TICK, 8'd254, 16'hFFFF);
    send_beat(CMD_NOP, 8'd254, 16'hFFFF);
  endtask

  task automatic test_allocation();
    set_idle(3);
    send_beat(CMD_ATTACH, 8'd0, 16'h0000);
    send_beat(CMD_ATTACH, 8'd254, 16'hFFFF);
    send_beat(CMD_ATTACH, 8'd0, 16'd7);       // same pin keeps its channel
    send_beat(CMD_ATTACH, 8'd170, 16'hAAAA);
    send_beat(CMD_ATTACH, 8'd85, 16'h5555);
    send_beat(CMD_ATTACH, 8'd99, 16'd1);      // all channels taken
    send_beat(CMD_DETACH, 8'd99, '0);         // pin not held
    send_beat(CMD_DETACH, 8'd170, '0);
    send_beat(CMD_ATTACH, 8'd99, 16'h1234);
    send_beat(CMD_DETACH, 8'd0, '0);
    send_beat(CMD_DETACH, 8'd254, '0);
    send_beat(CMD_DETACH, 8'd99, '0);
  endtask

  task automatic test_waveform_edges();
    wait_drained();
    write_reg(REG_PRESCALE, 16'd0);
    write_reg(REG_PERIOD, 16'd3);
    set_idle(2);
    send_beat(CMD_ATTACH, 8'd1, 16'd0);
    send_beat(CMD_ATTACH, 8'd2, 16'd2);       // duty on the limit count
    send_beat(CMD_ATTACH, 8'd3, 16'd1);
    repeat (8) send_beat(CMD_TICK, '0, '0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    set_idle(0);
    @(posedge clk);
    hold_request = 60;
    repeat (20) send_beat(CMD_TICK, 8'($urandom_range(254)), 16'($urandom));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int                  phase;
    int                  sent;
    int                  n;
    int                  tick_pct;
    int                  r;
    int                  floor_p;
    bit                  past_done;
    logic [PRESC_W-1:0]  div;
    logic [PERIOD_W-1:0] per;
    logic [PIN_W-1:0]    pin;
    logic [DUTY_W-1:0]   duty;
    phase     = 0;
    sent      = 0;
    past_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      set_idle(phase % 4);
      tick_pct = 78;
      n        = $urandom_range(90, 140);
      // keep the limit reachable from the present count
      floor_p  = int'(count_q) + 1;
      if (floor_p < 2) floor_p = 2;
      if (phase == 0) begin
        div = 8'd255; per = 16'(floor_p); n = 600; tick_pct = 97;
      end else if (phase == 1) begin
        div = 8'd0; per = 16'hFFFF; n = 150;
      end else if (!past_done && phase >= 4 && count_q >= 3) begin
        // drop the limit below the count: it must wrap all the way round
        div = 8'($urandom_range(3)); per = count_q; past_done = 1'b1;
      end else begin
        div = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        floor_p = floor_p + $urandom_range(30);
        per = (floor_p > 65535) ? 16'hFFFF : 16'(floor_p);
      end
      write_reg(REG_PRESCALE, 16'(div));
      write_reg(REG_PERIOD, per);
      for (int i = 0; i < n; i++) begin
        pin  = ($urandom_range(9) < 8) ? 8'($urandom_range(5)) : 8'($urandom_range(254));
        duty = ($urandom_range(3) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(int'(period_setting) + 1));
        r = $urandom_range(99);
        if (r < tick_pct) begin
          send_beat(CMD_TICK, pin, duty);
        end else begin
          r = $urandom_range(19);
          if (r <= 10) send_beat(CMD_ATTACH, pin, duty);
          else if (r <= 18) send_beat(CMD_DETACH, pin, duty);
          else send_beat(CMD_NOP, pin, duty);
        end
      end
      sent += n;
      phase++;
    end
  endtask

  initial begin
    timer_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_allocation();
    test_waveform_edges();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Checked %0d result beats for %0d commands; %0d attaches granted, %0d refused.",
             results_checked, beats_sent, attach_ok, attach_refused);
    $display("Timer ran %0d count events and %0d full PWM periods over %0d register writes.",
             count_events, periods_done, reg_writes);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
